[rtl/mcrst_pkg.sv]
`timescale 1ns / 1ps

package mcrst_pkg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef enum logic [5:0] {
        P_CHK, P_INV, P_PSQ, P_PML, P_PNX, P_C, P_C2, P_T1, P_T2,
        P_BN, P_BN2, P_B, P_B2, P_RS1, P_RS2, P_RS3,
        P_D1, P_D2, P_D3, P_D4, P_D5, P_D6, P_D7, P_D8, P_D9, P_D10,
        P_D11, P_D12, P_D13, P_D14, P_SQ1, P_SQ2
    } step_t;

    localparam int unsigned K_TWO      = 2;
    localparam int unsigned K_FOUR     = 4;
    localparam int unsigned K_EIGHTEEN = 18;
    localparam int unsigned K_TWSEVEN  = 27;

endpackage

[rtl/modular_cubic_root_split_test.sv]
`timescale 1ns / 1ps
// Channel   Handshake                Words
// input     in_valid / in_stall      first_residue, second_residue
// output    out_valid / out_stall    has_root, splits_fully
// config    cfg_valid / cfg_ready    cfg_data (prime modulus)
//
// One serial modular multiplier (operand width MB = max(bits,5)) under a step
// sequencer. Four Fermat powers cost about 4*2*bits products; the root search 2 products
// per candidate, the square test 1 per candidate. Degenerate pairs skip the multiplier.
// Reset is asynchronous; modulus resets to 5.
// A finished word waits in the output register; input stays stalled while working.

module modular_cubic_root_split_test #(
    parameter int MODULUS_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [MODULUS_BITS-1:0] first_residue,
    input  logic [MODULUS_BITS-1:0] second_residue,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    has_root,
    output logic                    splits_fully,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MODULUS_BITS-1:0] cfg_data
);
    import mcrst_pkg::*;

    localparam int N  = MODULUS_BITS;
    localparam int MB = (N < 5) ? 5 : N;
    localparam int CW = $clog2(MB + 1);
    localparam int BW = (N > 1) ? $clog2(N) : 1;

    state_t         state_reg, state_next;
    step_t          pc_reg, pc_next, ret_reg, ret_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [N-1:0]   p_reg;
    logic [N-1:0]   zi_reg, zj_reg, zi_next, zj_next;
    logic [N-1:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next, t_reg, t_next;
    logic [N-1:0]   e_reg, e_next, d_reg, d_next, u_reg, u_next, w_reg, w_next;
    logic [N-1:0]   res_reg, res_next;
    logic           fh_reg, fh_next, fs_reg, fs_next;
    logic           out_valid_reg, out_valid_next;
    logic           has_root_reg, has_root_next, splits_fully_reg, splits_fully_next;

    logic [N-1:0]   macc_reg, macc_next, mx_reg, mx_next;
    logic [MB-1:0]  my_reg, my_next;
    logic [CW-1:0]  mcnt_reg, mcnt_next;
    logic [N+1:0]   mt;
    logic [N-1:0]   mres;

    logic           go;
    logic [N-1:0]   gx;
    logic [MB-1:0]  gy;
    logic [N-1:0]   k3, k6, ex, tn, bd;
    logic [N:0]     k6w;
    logic           degen;

    function automatic logic [N-1:0] madd(input logic [N-1:0] x, input logic [N-1:0] y,
                                          input logic [N-1:0] m);
        logic [N:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[N-1:0];
    endfunction

    function automatic logic [N-1:0] msub(input logic [N-1:0] x, input logic [N-1:0] y,
                                          input logic [N-1:0] m);
        logic [N:0] s;
        if (x >= y)
            s = {1'b0, x} - {1'b0, y};
        else
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        return s[N-1:0];
    endfunction

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign has_root     = has_root_reg;
    assign splits_fully = splits_fully_reg;

    // serial multiplier: acc = 2*acc + bit*x mod p
    always_comb
    begin
        mt = {1'b0, macc_reg, 1'b0} + (my_reg[MB-1] ? {2'b00, mx_reg} : '0);
        if (mt >= {2'b00, p_reg})
            mt = mt - {2'b00, p_reg};
        if (mt >= {2'b00, p_reg})
            mt = mt - {2'b00, p_reg};
        mres = mt[N-1:0];
    end

    always_comb
    begin
        k6w = (N+1)'(6);
        if (k6w >= {1'b0, p_reg})
            k6w = k6w - {1'b0, p_reg};
        if (k6w >= {1'b0, p_reg})
            k6w = k6w - {1'b0, p_reg};
        k6 = k6w[N-1:0];
        k3 = (p_reg == N'(3)) ? '0 : N'(3);
        ex = p_reg - N'(2);
        degen = (p_reg < N'(3)) || (zi_reg >= p_reg) || (zj_reg >= p_reg) ||
                (zi_reg < N'(2)) || (zj_reg < N'(2));
        tn = msub(t_reg, res_reg, p_reg);
        bd = msub(tn, N'(1), p_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ret_next   = ret_reg;
        bit_next   = bit_reg;
        zi_next    = zi_reg;
        zj_next    = zj_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        u_next     = u_reg;
        w_next     = w_reg;
        res_next   = res_reg;
        fh_next    = fh_reg;
        fs_next    = fs_reg;
        macc_next  = macc_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mcnt_next  = mcnt_reg;
        go         = 1'b0;
        gx         = res_reg;
        gy         = MB'(res_reg);
        has_root_next     = has_root_reg;
        splits_fully_next = splits_fully_reg;
        out_valid_next    = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    zi_next    = first_residue;
                    zj_next    = second_residue;
                    pc_next    = P_CHK;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (pc_reg)
                    P_CHK:
                    begin
                        if (degen)
                        begin
                            fh_next    = 1'b1;
                            fs_next    = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            a_next  = msub(msub(k6, zi_reg, p_reg), zj_reg, p_reg);
                            go      = 1'b1;
                            gx      = zi_reg;
                            gy      = MB'(zj_reg);
                            pc_next = P_INV;
                        end
                    end
                    P_INV:
                    begin
                        e_next   = res_reg;
                        res_next = N'(1);
                        bit_next = BW'(N - 1);
                        ret_next = P_C;
                        pc_next  = P_PSQ;
                    end
                    P_PSQ:
                    begin
                        go      = 1'b1;
                        pc_next = P_PML;
                    end
                    P_PML:
                    begin
                        if (ex[bit_reg])
                        begin
                            go = 1'b1;
                            gy = MB'(e_reg);
                        end
                        pc_next = P_PNX;
                    end
                    P_PNX:
                    begin
                        if (bit_reg == '0)
                            pc_next = ret_reg;
                        else
                        begin
                            bit_next = bit_reg - 1'b1;
                            pc_next  = P_PSQ;
                        end
                    end
                    P_C:
                    begin
                        go      = 1'b1;
                        gy      = MB'(K_TWO);
                        pc_next = P_C2;
                    end
                    P_C2:
                    begin
                        c_next   = res_reg;
                        e_next   = msub(N'(1), zi_reg, p_reg);
                        res_next = N'(1);
                        bit_next = BW'(N - 1);
                        ret_next = P_T1;
                        pc_next  = P_PSQ;
                    end
                    P_T1:
                    begin
                        t_next   = msub(k3, res_reg, p_reg);
                        e_next   = msub(N'(1), zj_reg, p_reg);
                        res_next = N'(1);
                        bit_next = BW'(N - 1);
                        ret_next = P_T2;
                        pc_next  = P_PSQ;
                    end
                    P_T2:
                    begin
                        if (bd == '0)
                        begin
                            fh_next    = 1'b1;
                            fs_next    = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            t_next  = tn;
                            b_next  = msub(msub(k3, madd(a_reg, a_reg, p_reg), p_reg), tn,
                                           p_reg);
                            u_next  = madd(a_reg, c_reg, p_reg);
                            pc_next = P_BN;
                        end
                    end
                    P_BN:
                    begin
                        go      = 1'b1;
                        gx      = t_reg;
                        gy      = MB'(u_reg);
                        pc_next = P_BN2;
                    end
                    P_BN2:
                    begin
                        b_next   = madd(b_reg, res_reg, p_reg);
                        e_next   = msub(t_reg, N'(1), p_reg);
                        res_next = N'(1);
                        bit_next = BW'(N - 1);
                        ret_next = P_B;
                        pc_next  = P_PSQ;
                    end
                    P_B:
                    begin
                        go      = 1'b1;
                        gx      = b_reg;
                        pc_next = P_B2;
                    end
                    P_B2:
                    begin
                        b_next  = res_reg;
                        w_next  = '0;
                        pc_next = P_RS1;
                    end
                    P_RS1:
                    begin
                        go      = 1'b1;
                        gx      = msub(w_reg, a_reg, p_reg);
                        gy      = MB'(w_reg);
                        pc_next = P_RS2;
                    end
                    P_RS2:
                    begin
                        go      = 1'b1;
                        gx      = madd(res_reg, b_reg, p_reg);
                        gy      = MB'(w_reg);
                        pc_next = P_RS3;
                    end
                    P_RS3:
                    begin
                        if (res_reg == c_reg)
                            pc_next = P_D1;
                        else if (w_reg == p_reg - 1'b1)
                        begin
                            fh_next    = 1'b0;
                            fs_next    = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            w_next  = w_reg + 1'b1;
                            pc_next = P_RS1;
                        end
                    end
                    P_D1:
                    begin
                        go      = 1'b1;
                        gx      = a_reg;
                        gy      = MB'(b_reg);
                        pc_next = P_D2;
                    end
                    P_D2:
                    begin
                        u_next  = res_reg;
                        go      = 1'b1;
                        gy      = MB'(c_reg);
                        pc_next = P_D3;
                    end
                    P_D3:
                    begin
                        go      = 1'b1;
                        gy      = MB'(K_EIGHTEEN);
                        pc_next = P_D4;
                    end
                    P_D4:
                    begin
                        d_next  = res_reg;
                        go      = 1'b1;
                        gx      = u_reg;
                        gy      = MB'(u_reg);
                        pc_next = P_D5;
                    end
                    P_D5:
                    begin
                        d_next  = madd(d_reg, res_reg, p_reg);
                        go      = 1'b1;
                        gx      = a_reg;
                        gy      = MB'(a_reg);
                        pc_next = P_D6;
                    end
                    P_D6:
                    begin
                        go      = 1'b1;
                        gy      = MB'(a_reg);
                        pc_next = P_D7;
                    end
                    P_D7:
                    begin
                        go      = 1'b1;
                        gy      = MB'(c_reg);
                        pc_next = P_D8;
                    end
                    P_D8:
                    begin
                        go      = 1'b1;
                        gy      = MB'(K_FOUR);
                        pc_next = P_D9;
                    end
                    P_D9:
                    begin
                        d_next  = msub(d_reg, res_reg, p_reg);
                        go      = 1'b1;
                        gx      = b_reg;
                        gy      = MB'(b_reg);
                        pc_next = P_D10;
                    end
                    P_D10:
                    begin
                        go      = 1'b1;
                        gy      = MB'(b_reg);
                        pc_next = P_D11;
                    end
                    P_D11:
                    begin
                        go      = 1'b1;
                        gy      = MB'(K_FOUR);
                        pc_next = P_D12;
                    end
                    P_D12:
                    begin
                        d_next  = msub(d_reg, res_reg, p_reg);
                        go      = 1'b1;
                        gx      = c_reg;
                        gy      = MB'(c_reg);
                        pc_next = P_D13;
                    end
                    P_D13:
                    begin
                        go      = 1'b1;
                        gy      = MB'(K_TWSEVEN);
                        pc_next = P_D14;
                    end
                    P_D14:
                    begin
                        d_next  = msub(d_reg, res_reg, p_reg);
                        w_next  = '0;
                        pc_next = P_SQ1;
                    end
                    P_SQ1:
                    begin
                        go      = 1'b1;
                        gx      = w_reg;
                        gy      = MB'(w_reg);
                        pc_next = P_SQ2;
                    end
                    P_SQ2:
                    begin
                        if (res_reg == d_reg)
                        begin
                            fh_next    = 1'b1;
                            fs_next    = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (w_reg == p_reg - 1'b1)
                        begin
                            fh_next    = 1'b1;
                            fs_next    = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            w_next  = w_reg + 1'b1;
                            pc_next = P_SQ1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
                if (go)
                begin
                    macc_next  = '0;
                    mx_next    = gx;
                    my_next    = gy;
                    mcnt_next  = CW'(MB);
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                macc_next = mres;
                my_next   = {my_reg[MB-2:0], 1'b0};
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == CW'(1))
                begin
                    res_next   = mres;
                    state_next = S_EXEC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    has_root_next     = fh_reg;
                    splits_fully_next = fs_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            p_reg         <= N'(5);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                p_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg           <= pc_next;
        ret_reg          <= ret_next;
        bit_reg          <= bit_next;
        zi_reg           <= zi_next;
        zj_reg           <= zj_next;
        a_reg            <= a_next;
        b_reg            <= b_next;
        c_reg            <= c_next;
        t_reg            <= t_next;
        e_reg            <= e_next;
        d_reg            <= d_next;
        u_reg            <= u_next;
        w_reg            <= w_next;
        res_reg          <= res_next;
        fh_reg           <= fh_next;
        fs_reg           <= fs_next;
        macc_reg         <= macc_next;
        mx_reg           <= mx_next;
        my_reg           <= my_next;
        mcnt_reg         <= mcnt_next;
        has_root_reg     <= has_root_next;
        splits_fully_reg <= splits_fully_next;
    end

endmodule

[rtl/mcrst_checker.sv]
`timescale 1ns / 1ps

module mcrst_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic has_root,
    input logic splits_fully
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    a_split_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_root |-> !splits_fully)
        else $error("full split reported without a root");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word appeared without work in progress");

endmodule

bind modular_cubic_root_split_test mcrst_checker u_mcrst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_root     (has_root),
    .splits_fully (splits_fully)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MB = 10;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [MB-1:0] first_residue;
    logic [MB-1:0] second_residue;
    logic          out_valid;
    logic          out_stall;
    logic          has_root;
    logic          splits_fully;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [MB-1:0] cfg_data;

    typedef struct packed {
        logic root;
        logic split;
    } flags_t;

    flags_t flag_q[$];
    int     errors;
    int     src_idle_pct;
    int     dst_stall_pct;
    int     modulus;

    modular_cubic_root_split_test #(.MODULUS_BITS(MB)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_residue  (first_residue),
        .second_residue (second_residue),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .has_root       (has_root),
        .splits_fully   (splits_fully),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint mpow(longint b, longint e, longint p);
        longint r;
        longint x;
        begin
            r = 1 % p;
            x = b % p;
            while (e != 0)
            begin
                if (e & 1)
                    r = (r * x) % p;
                x = (x * x) % p;
                e = e >> 1;
            end
            return r;
        end
    endfunction

    function automatic longint msub(longint a, longint b, longint p);
        return (a % p + p - (b % p)) % p;
    endfunction

    function automatic flags_t cubic_flags(int zi_in, int zj_in, int pm);
        longint p, zi, zj, a, c, t, bd, bn, b, d, v, s;
        longint a2, a3, b2, b3, c2, pos, neg;
        flags_t f;
        bit found;
        bit sq;
        begin
            p = pm;
            zi = zi_in;
            zj = zj_in;
            f = '{1'b1, 1'b1};
            found = 1'b0;
            sq = 1'b0;
            if (p < 3 || zi >= p || zj >= p || zi < 2 || zj < 2)
                return f;
            a = msub(msub(6 % p, zi, p), zj, p);
            c = ((2 % p) * mpow(zi, p - 2, p)) % p;
            c = (c * mpow(zj, p - 2, p)) % p;
            t = msub(3 % p, mpow(msub(1, zi, p), p - 2, p), p);
            t = msub(t, mpow(msub(1, zj, p), p - 2, p), p);
            bd = msub(t, 1, p);
            if (bd == 0)
                return f;
            bn = msub(3 % p, (2 * a) % p, p);
            bn = msub(bn, t, p);
            bn = (bn + (t * ((a + c) % p)) % p) % p;
            b = (bn * mpow(bd, p - 2, p)) % p;
            for (longint w = 0; w < p && !found; w++)
            begin
                v = (w * w) % p;
                s = (v * w) % p;
                s = msub(s, (a * v) % p, p);
                s = (s + (b * w) % p) % p;
                s = msub(s, c, p);
                if (s == 0)
                    found = 1'b1;
            end
            a2 = (a * a) % p;
            a3 = (a2 * a) % p;
            b2 = (b * b) % p;
            b3 = (b2 * b) % p;
            c2 = (c * c) % p;
            pos = ((18 * ((a * b) % p)) % p * c) % p;
            pos = (pos + (a2 * b2) % p) % p;
            neg = ((4 * a3) % p * c) % p;
            neg = (neg + (4 * b3) % p) % p;
            neg = (neg + (27 * c2) % p) % p;
            d = msub(pos, neg, p);
            for (longint q = 0; q < p && !sq; q++)
                if ((q * q) % p == d)
                    sq = 1'b1;
            f.root = found;
            f.split = found & sq;
            return f;
        end
    endfunction

    // receiver side: stall and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (flag_q.size() == 0)
                begin
                    $display("%0t: unexpected word has_root=%0b splits_fully=%0b",
                             $time, has_root, splits_fully);
                    errors++;
                end
                else
                begin
                    flags_t e;
                    e = flag_q.pop_front();
                    if (e.root !== has_root)
                    begin
                        $display("%0t: has_root expected %0b actual %0b",
                                 $time, e.root, has_root);
                        errors++;
                    end
                    if (e.split !== splits_fully)
                    begin
                        $display("%0t: splits_fully expected %0b actual %0b",
                                 $time, e.split, splits_fully);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < dst_stall_pct);
        end
    end

    task automatic send_pair(int zi, int zj);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_residue <= zi[MB-1:0];
        second_residue <= zj[MB-1:0];
        flag_q.push_back(cubic_flags(zi, zj, modulus));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (flag_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_modulus(int p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= p[MB-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        modulus = p;
        @(posedge clk);
    endtask

    task automatic test_directed;
        send_pair(3, 4);
        set_modulus(7);
        send_pair(0, 3);
        send_pair(1, 4);
        send_pair(3, 7);
        send_pair(1023, 2);
        send_pair(2, 2);
        send_pair(3, 5);
        send_pair(6, 6);
        send_pair(4, 5);
        set_modulus(1021);
        send_pair(2, 1020);
        send_pair(1020, 1020);
        send_pair(1021, 5);
        send_pair(512, 341);
        send_pair(683, 170);
        set_modulus(0);
        send_pair(3, 4);
        set_modulus(1);
        send_pair(5, 9);
        set_modulus(2);
        send_pair(0, 1);
        set_modulus(9);
        send_pair(4, 7);
        send_pair(2, 5);
        set_modulus(1023);
        send_pair(700, 300);
    endtask

    task automatic test_random(int n);
        int primes[8] = '{5, 11, 13, 31, 61, 97, 251, 1021};
        int pick;
        for (int i = 0; i < n; i++)
        begin
            if (i % 10 == 0)
                set_modulus(primes[$urandom_range(7)]);
            pick = $urandom_range(9);
            if (pick == 0)
                send_pair($urandom_range(1023), $urandom_range(1023));
            else
                send_pair($urandom_range(modulus - 1), $urandom_range(modulus - 1));
        end
    endtask

    initial
    begin
        #500_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        modulus = 5;
        rst_n = 1'b0;
        in_valid = 1'b0;
        first_residue = '0;
        second_residue = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(29);
        src_idle_pct = 55;
        test_random(29);
        src_idle_pct = 0;
        dst_stall_pct = 55;
        test_random(29);
        src_idle_pct = 8;
        dst_stall_pct = 8;
        test_random(29);
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
